@@ rtl/qxm_pkg.sv @@
// qxm_pkg: widths, reset values, register indexes and the control/status
// structs shared by the quad x mixer controller, datapath and top level.
// no dependencies.
package qxm_pkg;

  localparam int CMD_W    = 12;            // motor command / throttle width
  localparam int CORR_W   = 12;            // roll and pitch correction width
  localparam int OFF_W    = 14;            // signed offset width
  localparam int HIST_W   = 13;            // stored command width
  localparam int DB_W     = 8;
  localparam int SLEW_W   = 10;
  localparam int CFG_W    = 12;
  localparam int IDX_W    = 2;
  localparam int MOTORS   = 4;
  localparam int MOTOR_W  = 2;
  localparam int Q_W      = 16;            // divider quotient bits
  localparam int SCALE_W  = 17;            // unsigned q1.16
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W   = 4;
  localparam int PROD_W   = 32;

  localparam logic [DB_W-1:0]    DB_RESET    = 8'd0;
  localparam logic [SLEW_W-1:0]  SLEW_RESET  = 10'd1023;
  localparam logic [CMD_W-1:0]   MIN_RESET   = 12'd1000;
  localparam logic [CMD_W-1:0]   MAX_RESET   = 12'd2000;
  localparam logic [HIST_W-1:0]  HIST_RESET  = 13'd1000;
  localparam logic [SCALE_W-1:0] SCALE_ONE   = 17'h10000;

  typedef enum logic [IDX_W-1:0] {
    REG_DEADBAND = 2'd0,
    REG_SLEW     = 2'd1,
    REG_MIN      = 2'd2,
    REG_MAX      = 2'd3
  } qxm_reg_t;

  typedef struct packed {
    logic               take;      // latch request, form base and offsets
    logic               prep;      // extremes, headroom flags, divider load
    logic               div_step;  // one quotient bit on both dividers
    logic               scale;     // pick the desaturation factor
    logic               mul;       // offset times scale for one motor
    logic               post;      // deadband, slew, clamp for one motor
    logic               load_out;  // move results into the output register
    logic [MOTOR_W-1:0] motor;
  } qxm_cmd_t;

  typedef struct packed {
    logic div_done;   // current divider step is the last one
  } qxm_stat_t;

endpackage

@@ rtl/qxm_in_if.sv @@
// qxm_in_if: request channel of the quad x mixer (throttle, roll, pitch).
// depends on qxm_pkg for field widths.
interface qxm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [qxm_pkg::CMD_W-1:0]      throttle_cmd;
  logic signed [qxm_pkg::CORR_W-1:0]     roll_correction;
  logic signed [qxm_pkg::CORR_W-1:0]     pitch_correction;

  modport source (output valid, throttle_cmd, roll_correction, pitch_correction,
                  input ready);
  modport sink   (input valid, throttle_cmd, roll_correction, pitch_correction,
                  output ready);
endinterface

@@ rtl/qxm_out_if.sv @@
// qxm_out_if: result channel of the quad x mixer (four motor commands).
// depends on qxm_pkg for field widths.
interface qxm_out_if;
  logic                        valid;
  logic                        ready;
  logic [qxm_pkg::CMD_W-1:0]   front_right_cmd;
  logic [qxm_pkg::CMD_W-1:0]   rear_right_cmd;
  logic [qxm_pkg::CMD_W-1:0]   rear_left_cmd;
  logic [qxm_pkg::CMD_W-1:0]   front_left_cmd;

  modport source (output valid, front_right_cmd, rear_right_cmd, rear_left_cmd,
                  front_left_cmd, input ready);
  modport sink   (input valid, front_right_cmd, rear_right_cmd, rear_left_cmd,
                  front_left_cmd, output ready);
endinterface

@@ rtl/qxm_ctrl.sv @@
// qxm_ctrl: sequencer for the quad x mixer; drives datapath commands and
// owns the request/result handshakes. depends on qxm_pkg.
module qxm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output qxm_pkg::qxm_cmd_t   cmd,
  input  qxm_pkg::qxm_stat_t  stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_POST  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t                       state, state_next;
  logic [qxm_pkg::MOTOR_W-1:0]  motor, motor_next;
  logic                         out_valid_next;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    motor_next     = motor;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.motor      = motor;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        motor_next = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        cmd.post = 1'b1;
        if (motor == qxm_pkg::MOTOR_W'(qxm_pkg::MOTORS - 1)) begin
          state_next = S_FIN;
        end else begin
          motor_next = motor + 1'b1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        // hold the new result until the output register drains
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      motor     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      motor     <= motor_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/qxm_dp.sv @@
// qxm_dp: quad x mixer datapath: config registers, mix, two restoring
// dividers for the headroom ratios, shared multiplier, slew history, outputs.
// depends on qxm_pkg.
module qxm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  qxm_pkg::qxm_cmd_t                 cmd,
  output qxm_pkg::qxm_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [qxm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [qxm_pkg::CFG_W-1:0]         cfg_data,
  input  logic [qxm_pkg::CMD_W-1:0]         throttle_cmd,
  input  logic signed [qxm_pkg::CORR_W-1:0] roll_correction,
  input  logic signed [qxm_pkg::CORR_W-1:0] pitch_correction,
  output logic [qxm_pkg::CMD_W-1:0]         front_right_cmd,
  output logic [qxm_pkg::CMD_W-1:0]         rear_right_cmd,
  output logic [qxm_pkg::CMD_W-1:0]         rear_left_cmd,
  output logic [qxm_pkg::CMD_W-1:0]         front_left_cmd
);

  localparam int CW = qxm_pkg::CMD_W;
  localparam int OW = qxm_pkg::OFF_W;
  localparam int HW = qxm_pkg::HIST_W;
  localparam int SW = OW + 1;   // post-processing sum width

  // configuration
  logic [qxm_pkg::DB_W-1:0]   deadband;
  logic [qxm_pkg::SLEW_W-1:0] slew;
  logic [CW-1:0]              lo_cmd, hi_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= qxm_pkg::DB_RESET;
      slew     <= qxm_pkg::SLEW_RESET;
      lo_cmd   <= qxm_pkg::MIN_RESET;
      hi_cmd   <= qxm_pkg::MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qxm_pkg::REG_DEADBAND: deadband <= cfg_data[qxm_pkg::DB_W-1:0];
        qxm_pkg::REG_SLEW:     slew     <= cfg_data[qxm_pkg::SLEW_W-1:0];
        qxm_pkg::REG_MIN:      lo_cmd   <= cfg_data[CW-1:0];
        qxm_pkg::REG_MAX:      hi_cmd   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // base and x mix offsets
  logic [CW-1:0]        base, base_next;
  logic signed [OW-1:0] off [qxm_pkg::MOTORS];
  logic signed [OW-1:0] roll_x, pitch_x;

  // lower bound is tested first, as when min sits above max
  always_comb begin
    if (throttle_cmd < lo_cmd)      base_next = lo_cmd;
    else if (throttle_cmd > hi_cmd) base_next = hi_cmd;
    else                            base_next = throttle_cmd;
  end

  assign roll_x  = OW'(roll_correction);
  assign pitch_x = OW'(pitch_correction);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      base   <= base_next;
      off[0] <= roll_x + pitch_x;
      off[1] <= pitch_x - roll_x;
      off[2] <= -roll_x - pitch_x;
      off[3] <= roll_x - pitch_x;
    end
  end

  // extremes and headroom
  logic signed [OW-1:0] omax, omin, max01, max23, min01, min23;
  logic signed [OW-1:0] base_s, lo_s, hi_s;
  logic signed [OW-1:0] room_up, span_up, room_lo, span_lo;
  logic                 up_cond_c, lo_cond_c;

  assign max01   = (off[1] > off[0]) ? off[1] : off[0];
  assign max23   = (off[3] > off[2]) ? off[3] : off[2];
  assign min01   = (off[1] < off[0]) ? off[1] : off[0];
  assign min23   = (off[3] < off[2]) ? off[3] : off[2];
  assign omax    = (max23 > max01) ? max23 : max01;
  assign omin    = (min23 < min01) ? min23 : min01;
  assign base_s  = $signed({2'b00, base});
  assign lo_s    = $signed({2'b00, lo_cmd});
  assign hi_s    = $signed({2'b00, hi_cmd});
  assign room_up = hi_s - base_s;
  assign span_up = omax;
  assign room_lo = base_s - lo_s;
  assign span_lo = -omin;
  assign up_cond_c = (base_s + omax) > hi_s;
  assign lo_cond_c = (base_s + omin) < lo_s;

  logic up_cond, up_zero, up_one, lo_cond, lo_zero, lo_one;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      up_cond <= up_cond_c;
      up_zero <= (room_up <= 0) || (span_up <= 0);
      up_one  <= room_up >= span_up;
      lo_cond <= lo_cond_c;
      lo_zero <= (room_lo <= 0) || (span_lo <= 0);
      lo_one  <= room_lo >= span_lo;
    end
  end

  // two restoring dividers: room * 2^16 / span, room < span
  logic [HW-1:0]             rem_up, dvs_up, rem_lo, dvs_lo;
  logic [qxm_pkg::Q_W-1:0]   q_up, q_lo;
  logic [qxm_pkg::DCNT_W-1:0] div_cnt;
  logic [HW:0]               t_up, t_lo;
  logic                      ge_up, ge_lo;

  assign t_up  = {rem_up, 1'b0};
  assign t_lo  = {rem_lo, 1'b0};
  assign ge_up = t_up >= {1'b0, dvs_up};
  assign ge_lo = t_lo >= {1'b0, dvs_lo};
  assign stat.div_done =
    (div_cnt == qxm_pkg::DCNT_W'(qxm_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_up  <= room_up[HW-1:0];
      dvs_up  <= span_up[HW-1:0];
      rem_lo  <= room_lo[HW-1:0];
      dvs_lo  <= span_lo[HW-1:0];
      q_up    <= '0;
      q_lo    <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_up  <= ge_up ? HW'(t_up - {1'b0, dvs_up}) : t_up[HW-1:0];
      rem_lo  <= ge_lo ? HW'(t_lo - {1'b0, dvs_lo}) : t_lo[HW-1:0];
      q_up    <= {q_up[qxm_pkg::Q_W-2:0], ge_up};
      q_lo    <= {q_lo[qxm_pkg::Q_W-2:0], ge_lo};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // desaturation factor
  logic [qxm_pkg::SCALE_W-1:0] r_up, r_lo, scale, scale_next, scale_a;

  always_comb begin
    if (up_zero)     r_up = '0;
    else if (up_one) r_up = qxm_pkg::SCALE_ONE;
    else             r_up = {1'b0, q_up};
    if (lo_zero)     r_lo = '0;
    else if (lo_one) r_lo = qxm_pkg::SCALE_ONE;
    else             r_lo = {1'b0, q_lo};
    scale_a    = up_cond ? r_up : qxm_pkg::SCALE_ONE;
    scale_next = (lo_cond && (r_lo < scale_a)) ? r_lo : scale_a;
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) scale <= scale_next;
  end

  // shared multiplier, one motor at a time
  logic signed [qxm_pkg::PROD_W-1:0] prod, off_ext, scl_ext;

  assign off_ext = qxm_pkg::PROD_W'(off[cmd.motor]);
  assign scl_ext = $signed({{(qxm_pkg::PROD_W - qxm_pkg::SCALE_W){1'b0}}, scale});

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= off_ext * scl_ext;
  end

  // deadband, slew limit and output clamp
  logic [HW-1:0]        hist [qxm_pkg::MOTORS];
  logic [CW-1:0]        res  [qxm_pkg::MOTORS];
  logic signed [OW-1:0] d, mag;
  logic signed [SW-1:0] mixed, snapped, last_s, slew_lo, slew_hi, limited;
  logic [CW-1:0]        clamped;

  always_comb begin
    d       = prod[qxm_pkg::Q_W+OW-1:qxm_pkg::Q_W];   // floor of product / 2^16
    mag     = d[OW-1] ? -d : d;
    mixed   = $signed({3'b000, base}) + SW'(d);
    snapped = ($unsigned(mag) < {{(OW - qxm_pkg::DB_W){1'b0}}, deadband}) ?
              $signed({3'b000, base}) : mixed;
    last_s  = $signed({2'b00, hist[cmd.motor]});
    slew_lo = last_s - $signed({5'b00000, slew});
    slew_hi = last_s + $signed({5'b00000, slew});
    if (snapped < slew_lo)      limited = slew_lo;
    else if (snapped > slew_hi) limited = slew_hi;
    else                        limited = snapped;
    if (limited < $signed({3'b000, lo_cmd}))      clamped = lo_cmd;
    else if (limited > $signed({3'b000, hi_cmd})) clamped = hi_cmd;
    else                                          clamped = limited[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qxm_pkg::MOTORS; i++) hist[i] <= qxm_pkg::HIST_RESET;
    end else if (cmd.post) begin
      hist[cmd.motor] <= limited[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) res[cmd.motor] <= clamped;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      front_right_cmd <= res[0];
      rear_right_cmd  <= res[1];
      rear_left_cmd   <= res[2];
      front_left_cmd  <= res[3];
    end
  end

endmodule

@@ rtl/quad_x_mixer_desat_slew.sv @@
// quad x mixer with desaturation and slew limiting: one result per request.
// a request is taken only in idle, so a new one waits until the previous result
// has gone into the output register, after the 16-step headroom dividers and the
// shared multiplier that visits the four motors in turn.
// reset: config registers to their defaults, motor history to 1000, no
// result pending. depends on qxm_pkg, qxm_in_if, qxm_out_if, qxm_ctrl, qxm_dp.
module quad_x_mixer_desat_slew (
  input  logic                       clk,
  input  logic                       rst,
  qxm_in_if.sink                     cmd_in,
  qxm_out_if.source                  motor_out,
  input  logic                       cfg_we,
  input  logic [qxm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [qxm_pkg::CFG_W-1:0]  cfg_data
);

  qxm_pkg::qxm_cmd_t  cmd;
  qxm_pkg::qxm_stat_t stat;

  qxm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_ready  (cmd_in.ready),
    .out_valid (motor_out.valid),
    .out_ready (motor_out.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qxm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .throttle_cmd     (cmd_in.throttle_cmd),
    .roll_correction  (cmd_in.roll_correction),
    .pitch_correction (cmd_in.pitch_correction),
    .front_right_cmd  (motor_out.front_right_cmd),
    .rear_right_cmd   (motor_out.rear_right_cmd),
    .rear_left_cmd    (motor_out.rear_left_cmd),
    .front_left_cmd   (motor_out.front_left_cmd)
  );

endmodule

@@ rtl/qxm_check.sv @@
// qxm_check: port-level checks for the quad x mixer, bound to the top level.
// depends on qxm_pkg and the top-level port interfaces.
module qxm_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [qxm_pkg::CMD_W-1:0] front_right_cmd,
  input logic [qxm_pkg::CMD_W-1:0] rear_right_cmd,
  input logic [qxm_pkg::CMD_W-1:0] rear_left_cmd,
  input logic [qxm_pkg::CMD_W-1:0] front_left_cmd
);

  logic       in_acc, out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else     pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
  end

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable({front_right_cmd, rear_right_cmd, rear_left_cmd, front_left_cmd}))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without a request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two requests outstanding");

endmodule

bind quad_x_mixer_desat_slew qxm_check u_qxm_check (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (cmd_in.valid),
  .in_ready        (cmd_in.ready),
  .out_valid       (motor_out.valid),
  .out_ready       (motor_out.ready),
  .front_right_cmd (motor_out.front_right_cmd),
  .rear_right_cmd  (motor_out.rear_right_cmd),
  .rear_left_cmd   (motor_out.rear_left_cmd),
  .front_left_cmd  (motor_out.front_left_cmd)
);

@@ sim/qxm_mix_checker.sv @@
// qxm_mix_checker: watches the request, result and register ports of the quad x mixer,
// predicts the four motor commands of every request and compares them in order.
// depends on qxm_pkg, qxm_in_if and qxm_out_if.
`timescale 1ns / 100ps
module qxm_mix_checker
  import qxm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  qxm_in_if                cmd_ch,
  qxm_out_if               motor_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [CMD_W-1:0] fr;
    logic [CMD_W-1:0] rr;
    logic [CMD_W-1:0] rl;
    logic [CMD_W-1:0] fl;
  } motor_cmds_t;

  int          dead_band;
  int          slew_step;
  int          cmd_floor;
  int          cmd_ceil;
  int          last_cmd [MOTORS];
  motor_cmds_t expected_cmds [$];
  motor_cmds_t want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // lower bound is tested first, so min above max pins everything else to max
  function automatic int bound(int x, int lo_b, int hi_b);
    if (x < lo_b) return lo_b;
    if (x > hi_b) return hi_b;
    return x;
  endfunction

  function automatic longint headroom_ratio(int room, int span);
    if (room <= 0 || span <= 0) return 0;
    if (room >= span) return longint'(SCALE_ONE);
    return (longint'(room) << Q_W) / span;
  endfunction

  function automatic motor_cmds_t mix_motors(logic [CMD_W-1:0] thr,
                                             logic signed [CORR_W-1:0] roll,
                                             logic signed [CORR_W-1:0] pitch);
    int          base;
    int          r;
    int          p;
    int          top_off;
    int          bot_off;
    int          d;
    int          cmd;
    int          off [MOTORS];
    logic [CMD_W-1:0] outs [MOTORS];
    longint      scale;
    longint      ratio;
    motor_cmds_t res;
    r = roll;
    p = pitch;
    base = bound(int'(thr), cmd_floor, cmd_ceil);
    off[0] = r + p;
    off[1] = p - r;
    off[2] = -r - p;
    off[3] = r - p;
    top_off = off[0];
    bot_off = off[0];
    for (int i = 1; i < MOTORS; i++) begin
      if (off[i] > top_off) top_off = off[i];
      if (off[i] < bot_off) bot_off = off[i];
    end
    scale = longint'(SCALE_ONE);
    if (base + top_off > cmd_ceil) scale = headroom_ratio(cmd_ceil - base, top_off);
    if (base + bot_off < cmd_floor) begin
      ratio = headroom_ratio(base - cmd_floor, -bot_off);
      if (ratio < scale) scale = ratio;
    end
    for (int i = 0; i < MOTORS; i++) begin
      // arithmetic shift floors negative offsets too
      d = int'((longint'(off[i]) * scale) >>> Q_W);
      cmd = (d < dead_band && -d < dead_band) ? base : base + d;
      cmd = bound(cmd, last_cmd[i] - slew_step, last_cmd[i] + slew_step);
      last_cmd[i] = cmd;
      outs[i] = CMD_W'(bound(cmd, cmd_floor, cmd_ceil));
    end
    res.fr = outs[0];
    res.rr = outs[1];
    res.rl = outs[2];
    res.fl = outs[3];
    return res;
  endfunction

  task automatic check_field(string name, logic [CMD_W-1:0] exp_val, logic [CMD_W-1:0] got);
    if (exp_val !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dead_band = int'(DB_RESET);
      slew_step = int'(SLEW_RESET);
      cmd_floor = int'(MIN_RESET);
      cmd_ceil  = int'(MAX_RESET);
      for (int i = 0; i < MOTORS; i++) last_cmd[i] = int'(HIST_RESET);
      expected_cmds.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (qxm_reg_t'(cfg_index))
          REG_DEADBAND: dead_band = int'(cfg_data[DB_W-1:0]);
          REG_SLEW:     slew_step = int'(cfg_data[SLEW_W-1:0]);
          REG_MIN:      cmd_floor = int'(cfg_data[CMD_W-1:0]);
          REG_MAX:      cmd_ceil  = int'(cfg_data[CMD_W-1:0]);
          default: ;
        endcase
      end
      if (cmd_ch.valid && cmd_ch.ready)
        expected_cmds.push_back(mix_motors(cmd_ch.throttle_cmd, cmd_ch.roll_correction,
                                           cmd_ch.pitch_correction));
      if (motor_ch.valid && motor_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with no request waiting, expected none, got %0d %0d %0d %0d",
                   $time, motor_ch.front_right_cmd, motor_ch.rear_right_cmd,
                   motor_ch.rear_left_cmd, motor_ch.front_left_cmd);
        end else begin
          want = expected_cmds.pop_front();
          check_field("front_right_cmd", want.fr, motor_ch.front_right_cmd);
          check_field("rear_right_cmd",  want.rr, motor_ch.rear_right_cmd);
          check_field("rear_left_cmd",   want.rl, motor_ch.rear_left_cmd);
          check_field("front_left_cmd",  want.fl, motor_ch.front_left_cmd);
        end
      end
      outstanding <= expected_cmds.size();
    end
  end

endmodule

@@ sim/tb_quad_x_mixer_desat_slew.sv @@
// tb_quad_x_mixer_desat_slew: drives requests, register writes and result backpressure
// into the quad x mixer; qxm_mix_checker predicts and compares, this module gives the verdict.
// depends on qxm_pkg, qxm_in_if, qxm_out_if, qxm_mix_checker and the mixer rtl.
`timescale 1ns / 100ps
module tb_quad_x_mixer_desat_slew;
  import qxm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE         = 30;
  localparam int PER_SETTING    = 60;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               outstanding;
  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_request;
  bit               hold_served;
  int               sent_count;
  int               setting_count;
  int               cur_lo;
  int               cur_hi;
  int               quiet;

  qxm_in_if  cmd_ch ();
  qxm_out_if motor_ch ();

  quad_x_mixer_desat_slew dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd_ch),
    .motor_out (motor_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qxm_mix_checker mix_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_ch      (cmd_ch),
    .motor_ch    (motor_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    motor_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        motor_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        motor_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (motor_ch.valid && motor_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic put_reg(qxm_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(int db, int sl, int lo, int hi);
    put_reg(REG_DEADBAND, db[CFG_W-1:0]);
    put_reg(REG_SLEW, sl[CFG_W-1:0]);
    put_reg(REG_MIN, lo[CFG_W-1:0]);
    put_reg(REG_MAX, hi[CFG_W-1:0]);
    cfg_we <= 1'b0;
    cur_lo = lo % 4096;
    cur_hi = hi % 4096;
    setting_count++;
  endtask

  task automatic send_request(int thr, int roll, int pitch);
    cmd_ch.valid            <= 1'b1;
    cmd_ch.throttle_cmd     <= thr[CMD_W-1:0];
    cmd_ch.roll_correction  <= roll[CORR_W-1:0];
    cmd_ch.pitch_correction <= pitch[CORR_W-1:0];
    do @(posedge clk); while (!cmd_ch.ready);
    sent_count++;
  endtask

  task automatic idle_gap();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid        <= 1'b0;
      cmd_ch.throttle_cmd <= CMD_W'($urandom());
      @(posedge clk);
    end
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int random_corr();
    int v;
    case ($urandom_range(0, 2))
      0:       v = $urandom_range(0, 128) - 64;
      1:       v = $urandom_range(0, 1024) - 512;
      default: v = $urandom_range(0, 4095) - 2048;
    endcase
    return v;
  endfunction

  task automatic pick_settings();
    int db;
    int sl;
    int lo;
    int hi;
    case ($urandom_range(0, 7))
      0: begin
        db = $urandom_range(0, 1) * 255;
        sl = $urandom_range(0, 1) * 1023;
        lo = $urandom_range(0, 1) * 4095;
        hi = $urandom_range(0, 1) * 4095;
      end
      1: begin
        // min above max
        lo = $urandom_range(1, 4095);
        hi = $urandom_range(0, lo - 1);
        db = $urandom_range(0, 255);
        sl = $urandom_range(0, 1023);
      end
      default: begin
        lo = $urandom_range(0, 2500);
        hi = $urandom_range(lo, 4095);
        db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
        sl = $urandom_range(0, 1) ? 1023 : $urandom_range(0, 300);
      end
    endcase
    // unused upper data bits carry noise
    db = db | ($urandom_range(0, 15) << DB_W);
    sl = sl | ($urandom_range(0, 3) << SLEW_W);
    write_settings(db, sl, lo, hi);
  endtask

  task automatic random_request();
    int thr;
    if (cur_lo <= cur_hi && $urandom_range(0, 3) != 0)
      thr = $urandom_range(cur_lo, cur_hi);
    else
      thr = $urandom_range(0, 4095);
    send_request(thr, random_corr(), random_corr());
  endtask

  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_DEADBAND;
    cfg_data                = '0;
    cmd_ch.valid            = 1'b0;
    cmd_ch.throttle_cmd     = '0;
    cmd_ch.roll_correction  = '0;
    cmd_ch.pitch_correction = '0;
    send_idle_pct           = 0;
    recv_idle_pct           = 0;
    hold_request            = 1'b0;
    hold_served             = 1'b0;
    sent_count              = 0;
    setting_count           = 1;
    cur_lo                  = int'(MIN_RESET);
    cur_hi                  = int'(MAX_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: plain mix, field extremes, desaturation on each side and both
    send_request(1500, 0, 0);
    send_request(4095, 2047, 2047);
    send_request(0, -2048, -2048);
    send_request(1500, 2047, -2048);
    send_request(1500, -2048, 2047);
    send_request(1900, 300, 200);
    send_request(1100, -300, 150);
    send_request(1500, 600, 0);
    drain();
    // deadband snap, right at the edge too
    write_settings(255, 1023, 1000, 2000);
    send_request(1500, 100, 50);
    send_request(1500, 254, 1);
    drain();
    // slew of zero freezes the motors, then a tight slew
    write_settings(0, 0, 1000, 2000);
    send_request(2000, 500, 500);
    drain();
    write_settings(0, 25, 1000, 2000);
    send_request(1900, 40, -30);
    send_request(1000, -400, 400);
    drain();
    // min above max
    write_settings(0, 1023, 1800, 1200);
    send_request(1500, 100, -100);
    send_request(0, 2047, 0);
    send_request(4095, 0, -2048);
    drain();
    // full output range
    write_settings(255, 1023, 0, 4095);
    send_request(4095, 2047, 2047);
    send_request(0, -2048, -2048);
    send_request(2048, 2047, -2048);
    drain();
    write_settings(0, 1023, 4095, 4095);
    send_request(100, 5, -5);
    drain();
    write_settings(0, 1023, 0, 0);
    send_request(4095, 0, 0);
    drain();
    write_settings(0, 1, 0, 4095);
    send_request(1000, -7, 3);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 32 : 0;
      for (int s = 0; s < 6; s++) begin
        pick_settings();
        // block fills up behind a stalled result port
        if (ph == 2 && s == 0) hold_request = 1'b1;
        for (int n = 0; n < PER_SETTING; n++) begin
          idle_gap();
          random_request();
        end
        drain();
      end
    end

    repeat (40) @(posedge clk);
    $display("covered %0d requests over %0d register settings, three pacing mixes",
             sent_count, setting_count);
    $display("and one long result stall; %0d field mismatches", fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
